>>> design/tcw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_pkg: shared types and constants of the text console writer
// Request and result payloads, controller commands and datapath status.
// ----------------------------------------------------------------------------
package tcw_pkg;

  // Cell words and attribute masks.
  localparam logic [15:0] RESET_CELL    = 16'h0700;
  localparam logic [15:0] KEEP_ON_WRITE = 16'h8F00;
  localparam logic [15:0] KEEP_ON_CLEAR = 16'hFF00;
  localparam logic [7:0]  SPACE_CODE    = 8'h20;

  // Character codes with a special meaning.
  localparam logic [7:0] CODE_NONE = 8'd0;
  localparam logic [7:0] CODE_BS   = 8'd8;
  localparam logic [7:0] CODE_TAB  = 8'd9;
  localparam logic [7:0] CODE_NL   = 8'd10;

  // Request function codes.
  localparam logic FUNC_PUT  = 1'b0;
  localparam logic FUNC_READ = 1'b1;

  typedef struct packed {
    logic        func;
    logic [7:0]  char_code;
    logic [10:0] read_address;
  } tcw_in_t;

  typedef struct packed {
    logic        cell_written;
    logic [10:0] cell_address;
    logic [15:0] cell_value;
    logic        screen_cleared;
    logic [6:0]  cursor_column;
    logic [4:0]  cursor_row;
  } tcw_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic init_wr;
    logic load;
    logic rd_user;
    logic emit_zero;
    logic wrap;
    logic clr_start;
    logic clr_rd;
    logic clr_wr;
    logic act;
    logic wr_cell;
    logic emit_read;
  } tcw_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_read;
    logic code_zero;
    logic need_clear;
    logic act_writes;
    logic cnt_last;
  } tcw_status_t;

endpackage

>>> design/tcw_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_ctrl: sequencer of the text console writer
// Steps through start-up fill, request decode, screen clear and cell update.
// ----------------------------------------------------------------------------
module tcw_ctrl
  import tcw_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  tcw_status_t st,
  output tcw_cmd_t    cmd,
  output logic        busy
);

  localparam logic [2:0] S_INIT   = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_EVAL   = 3'd2;
  localparam logic [2:0] S_CLR_RD = 3'd3;
  localparam logic [2:0] S_CLR_WR = 3'd4;
  localparam logic [2:0] S_ACT    = 3'd5;
  localparam logic [2:0] S_WR     = 3'd6;
  localparam logic [2:0] S_RDW    = 3'd7;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  // Next state and command decode.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_INIT: begin
        cmd.init_wr = 1'b1;
        if (st.cnt_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        if (st.is_read) begin
          cmd.rd_user = 1'b1;
          state_nxt   = S_RDW;
        end else if (st.code_zero) begin
          cmd.emit_zero = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          cmd.wrap = 1'b1;
          if (st.need_clear) begin
            cmd.clr_start = 1'b1;
            state_nxt     = S_CLR_RD;
          end else begin
            state_nxt = S_ACT;
          end
        end
      end
      S_CLR_RD: begin
        cmd.clr_rd = 1'b1;
        state_nxt  = S_CLR_WR;
      end
      S_CLR_WR: begin
        cmd.clr_wr = 1'b1;
        state_nxt  = st.cnt_last ? S_ACT : S_CLR_RD;
      end
      S_ACT: begin
        cmd.act   = 1'b1;
        state_nxt = st.act_writes ? S_WR : S_IDLE;
      end
      S_WR: begin
        cmd.wr_cell = 1'b1;
        state_nxt   = S_IDLE;
      end
      S_RDW: begin
        cmd.emit_read = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_INIT;
      end
    endcase
  end

  // State register; reset starts the fill of the screen memory.
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_INIT;
    else        state_r <= state_nxt;
  end

  assign busy = (state_r != S_IDLE);

endmodule

>>> design/tcw_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_datapath: screen memory, cursor and result register
// Holds the cell store and cursor and forms each result under controller command.
// ----------------------------------------------------------------------------
module tcw_datapath
  import tcw_pkg::*;
#(
  parameter int COLUMNS  = 80,
  parameter int ROWS     = 25,
  parameter int TAB_STEP = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  tcw_in_t     in_data,
  input  tcw_cmd_t    cmd,
  output tcw_status_t st,
  output logic        out_valid,
  output tcw_out_t    out_data
);

  localparam int CELLS  = COLUMNS * ROWS;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int COL_W  = $clog2(COLUMNS + TAB_STEP);
  localparam int ROW_W  = $clog2(ROWS + 2);
  localparam int WIDE_W = (ADDR_W > 11) ? ADDR_W : 11;
  localparam int COL_X  = (COL_W > 7) ? COL_W : 7;
  localparam int ROW_X  = (ROW_W > 5) ? ROW_W : 5;

  tcw_in_t           req_r;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic              cleared_r, cleared_nxt;
  logic [ADDR_W-1:0] cnt_r, cnt_nxt;
  logic [ADDR_W-1:0] waddr_r;
  logic [15:0]       rdata_r;
  logic [15:0]       mem [CELLS];
  logic              out_valid_r;
  tcw_out_t          out_r;

  // Wrap step ahead of a put.
  logic              col_over;
  logic [COL_W-1:0]  wrap_col;
  logic [ROW_W-1:0]  wrap_row;

  assign col_over = (col_r >= COL_W'(COLUMNS));
  assign wrap_col = col_over ? '0 : col_r;
  assign wrap_row = col_over ? row_r + ROW_W'(1) : row_r;

  // Character handling on a wrapped cursor.
  logic              is_bs, is_tab, is_nl;
  logic              act_writes;
  logic [COL_W-1:0]  act_col, tgt_col;
  logic [ROW_W-1:0]  act_row, tgt_row;
  logic [ADDR_W-1:0] act_addr;

  assign is_bs  = (req_r.char_code == CODE_BS);
  assign is_tab = (req_r.char_code == CODE_TAB);
  assign is_nl  = (req_r.char_code == CODE_NL);

  always_comb begin
    act_writes = 1'b1;
    tgt_col    = col_r;
    tgt_row    = row_r;
    act_col    = col_r + COL_W'(1);
    act_row    = row_r;
    if (is_nl) begin
      act_writes = 1'b0;
      act_col    = '0;
      act_row    = row_r + ROW_W'(1);
    end else if (is_tab) begin
      act_writes = 1'b0;
      act_col    = col_r + COL_W'(TAB_STEP);
    end else if (is_bs) begin
      if (row_r == '0) begin
        act_writes = 1'b0;
        act_col    = col_r;
      end else begin
        if (col_r == '0) begin
          tgt_row = row_r - ROW_W'(1);
          tgt_col = COL_W'(COLUMNS - 1);
        end else begin
          tgt_col = col_r - COL_W'(1);
        end
        act_col = tgt_col;
        act_row = tgt_row;
      end
    end
  end

  assign act_addr = ADDR_W'(tgt_row) * ADDR_W'(COLUMNS) + ADDR_W'(tgt_col);

  // Read address of a read request and its range check.
  logic [WIDE_W-1:0] raddr_w;
  logic              raddr_ok;

  assign raddr_w  = WIDE_W'(req_r.read_address);
  assign raddr_ok = (raddr_w < WIDE_W'(CELLS));

  // Status to the controller.
  assign st.is_read    = (req_r.func == FUNC_READ);
  assign st.code_zero  = (req_r.char_code == CODE_NONE);
  assign st.need_clear = (wrap_row >= ROW_W'(ROWS));
  assign st.act_writes = act_writes;
  assign st.cnt_last   = (cnt_r == ADDR_W'(CELLS - 1));

  // Cursor and clear flag update.
  always_comb begin
    col_nxt     = col_r;
    row_nxt     = row_r;
    cleared_nxt = cleared_r;
    if (cmd.load) cleared_nxt = 1'b0;
    if (cmd.wrap) begin
      col_nxt = wrap_col;
      row_nxt = wrap_row;
    end
    if (cmd.clr_start) begin
      col_nxt     = '0;
      row_nxt     = '0;
      cleared_nxt = 1'b1;
    end
    if (cmd.act) begin
      col_nxt = act_col;
      row_nxt = act_row;
    end
  end

  // Sweep counter for the start-up fill and the screen clear.
  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.init_wr || cmd.clr_wr) begin
      cnt_nxt = st.cnt_last ? '0 : cnt_r + ADDR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r     <= '0;
      row_r     <= '0;
      cleared_r <= 1'b0;
      cnt_r     <= '0;
    end else begin
      col_r     <= col_nxt;
      row_r     <= row_nxt;
      cleared_r <= cleared_nxt;
      cnt_r     <= cnt_nxt;
    end
  end

  // Request and write address capture.
  always_ff @(posedge clk) begin
    if (cmd.load) req_r <= in_data;
    if (cmd.act)  waddr_r <= act_addr;
  end

  // Memory port selection.
  logic              wr_en, rd_en;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  logic [15:0]       wr_data, cell_val;
  logic [7:0]        put_code;

  assign put_code = is_bs ? SPACE_CODE : req_r.char_code;
  assign cell_val = (rdata_r & KEEP_ON_WRITE) | {8'h00, put_code};

  assign wr_en   = cmd.init_wr | cmd.clr_wr | cmd.wr_cell;
  assign wr_addr = cmd.wr_cell ? waddr_r : cnt_r;
  assign wr_data = cmd.init_wr ? RESET_CELL :
                   cmd.clr_wr  ? (rdata_r & KEEP_ON_CLEAR) : cell_val;

  assign rd_en   = cmd.rd_user | cmd.clr_rd | (cmd.act & act_writes);
  assign rd_addr = cmd.rd_user ? raddr_w[ADDR_W-1:0] :
                   cmd.clr_rd  ? cnt_r : act_addr;

  // Screen memory with registered read data.
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rdata_r <= mem[rd_addr];
  end

  // Result register, shown for one cycle.
  logic              emit;
  logic [COL_X-1:0]  col_x;
  logic [ROW_X-1:0]  row_x;
  logic [WIDE_W-1:0] waddr_x;

  assign emit    = cmd.emit_zero | cmd.emit_read | cmd.wr_cell | (cmd.act & ~act_writes);
  assign col_x   = COL_X'(col_nxt);
  assign row_x   = ROW_X'(row_nxt);
  assign waddr_x = WIDE_W'(waddr_r);

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= emit;
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_r.cursor_column  <= col_x[6:0];
      out_r.cursor_row     <= row_x[4:0];
      out_r.screen_cleared <= cleared_r & ~cmd.emit_zero & ~cmd.emit_read;
      if (cmd.emit_read) begin
        out_r.cell_written <= 1'b0;
        out_r.cell_address <= req_r.read_address;
        out_r.cell_value   <= raddr_ok ? rdata_r : 16'h0000;
      end else if (cmd.wr_cell) begin
        out_r.cell_written <= 1'b1;
        out_r.cell_address <= waddr_x[10:0];
        out_r.cell_value   <= cell_val;
      end else begin
        out_r.cell_written <= 1'b0;
        out_r.cell_address <= '0;
        out_r.cell_value   <= '0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

>>> design/text_console_writer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_writer: text screen of 16-bit cells with a cursor
// Puts characters on the screen and reads single cells back.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; its one result
// appears for a single cycle with out_valid and must be captured then, since
// the receiver cannot hold it off. After reset the block fills its screen
// memory with grey blanks, one cell a cycle, with busy high. A request is
// then decoded; an ignored code zero ends there, a cell read adds the read,
// a newline, tab or backspace on the top row adds a cursor step, and a
// character or other backspace adds a cursor step with a read-modify-write
// of one cell. A put that scrolls past the last row first clears the screen
// with a read and a write of every cell. The result strobe is registered and
// appears in the cycle after the last busy cycle of its request.
module text_console_writer
  import tcw_pkg::*;
#(
  parameter int COLUMNS  = 80,
  parameter int ROWS     = 25,
  parameter int TAB_STEP = 4
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  tcw_in_t  in_data,
  output logic     busy,
  output logic     out_valid,
  output tcw_out_t out_data
);

  tcw_cmd_t    cmd;
  tcw_status_t st;

  // Sequencer.
  tcw_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .st    (st),
    .cmd   (cmd),
    .busy  (busy)
  );

  // Screen store, cursor and result.
  tcw_datapath #(
    .COLUMNS  (COLUMNS),
    .ROWS     (ROWS),
    .TAB_STEP (TAB_STEP)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .st        (st),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
